// ===== design/ffbe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffbe_pkg: shared types and helpers for the framebuffer fill and blend engine
// Command and read-back payload structs, command codes, register indexes,
// size defaults, dimension saturation and the per-channel blend function.
// ----------------------------------------------------------------------------
package ffbe_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;

    localparam int DIM_W      = 10;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [2:0] KIND_CLEAR       = 3'd0;
    localparam logic [2:0] KIND_SOLID_PIXEL = 3'd1;
    localparam logic [2:0] KIND_BLEND_PIXEL = 3'd2;
    localparam logic [2:0] KIND_SOLID_RECT  = 3'd3;
    localparam logic [2:0] KIND_BLEND_RECT  = 3'd4;
    localparam logic [2:0] KIND_READ        = 3'd5;

    typedef struct packed {
        logic [2:0] kind;
        logic [8:0] x_pos;
        logic [8:0] y_pos;
        logic [9:0] rect_width;
        logic [9:0] rect_height;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } cmd_t;

    typedef struct packed {
        logic [7:0] read_red;
        logic [7:0] read_green;
        logic [7:0] read_blue;
    } pix_t;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v, input int hi);
        if (v == '0) begin
            return DIM_W'(1);
        end
        if (int'(v) > hi) begin
            return DIM_W'(hi);
        end
        return v;
    endfunction

    function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] s,
                                       input logic [7:0] d);
        logic [7:0]  na;
        logic [15:0] p_src;
        logic [15:0] p_dst;
        logic [16:0] acc;
        na    = 8'd255 - a;
        p_src = 16'(a) * 16'(s);
        p_dst = 16'(na) * 16'(d);
        acc   = {1'b0, p_src} + {1'b0, p_dst};
        return acc[15:8];
    endfunction

endpackage
`default_nettype wire

// ===== design/ffbe_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffbe_ram: generic simple dual-port ram
// One write port and one read port, read data registered, read-before-write.
// ----------------------------------------------------------------------------
module ffbe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== design/framebuffer_fill_blend_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// framebuffer_fill_blend_engine: rectangle fill and alpha blend engine
// RGB frame store with clear, pixel, rectangle and read-back commands.
// ----------------------------------------------------------------------------
// usage
//   s_valid/s_ready/s_data carry one command per transaction; m_valid/m_ready/
//   m_data return one pixel for each read command, none for other commands.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write frame_width (0) and
//   frame_height (1); values saturate to the frame store size. write them
//   only while no command is in flight.
//   pixel commands are taken one per cycle while no rectangle or clear is
//   being drawn. a rectangle is set up when accepted, then draws one pixel
//   per cycle for each pixel left after clipping; a clear draws all the
//   frame_width*frame_height pixels at that rate, set by the single write
//   port of the frame store, which every drawn pixel passes once. read data
//   passes the stage 1, 2 and 3 registers and the result register before it
//   appears on m_data. only one read is in flight at a time: a read command
//   waits at the input while an earlier read result is untaken or still in
//   the pipeline; other commands keep flowing while a result waits on m_valid.
//   reset returns both size registers to their defaults and empties the
//   pipeline; frame store contents stay undefined until cleared or written.
// ----------------------------------------------------------------------------
module framebuffer_fill_blend_engine #(
    parameter int MAX_WIDTH  = ffbe_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ffbe_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire ffbe_pkg::cmd_t                    s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output ffbe_pkg::pix_t                         m_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ffbe_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [ffbe_pkg::DIM_W-1:0]        cfg_data
);

    import ffbe_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = 2 * DIM_W;

    typedef enum logic [2:0] {
        GEN_IDLE  = 3'b001,
        GEN_RECT  = 3'b010,
        GEN_CLEAR = 3'b100
    } gen_state_t;

    typedef struct packed {
        logic        rd;
        logic        blend;
        logic        zero;
        logic [23:0] color;
        logic [7:0]  alpha;
    } pix_op_t;

    // configuration
    logic [DIM_W-1:0] fw_reg, fh_reg;

    // generator
    gen_state_t       state_reg, state_next;
    logic [DIM_W-1:0] cur_x_reg, cur_x_next;
    logic [DIM_W-1:0] cur_y_reg, cur_y_next;
    logic [DIM_W-1:0] x_start_reg, x_start_next;
    logic [DIM_W:0]   x_end_reg, x_end_next;
    logic [DIM_W:0]   y_end_reg, y_end_next;
    logic [LW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [LW-1:0]    clr_last_reg, clr_last_next;
    logic [23:0]      color_reg, color_next;
    logic [7:0]       alpha_reg, alpha_next;
    logic             blend_reg, blend_next;

    // stage 1: pixel operation in screen coordinates or linear address
    logic             op1_valid_reg, op1_valid_next;
    pix_op_t          op1_op_reg, op1_op_next;
    logic             op1_direct_reg, op1_direct_next;
    logic [DIM_W-1:0] op1_x_reg, op1_x_next;
    logic [DIM_W-1:0] op1_y_reg, op1_y_next;
    logic [LW-1:0]    op1_lin_reg, op1_lin_next;

    // stage 2: address known, frame store read issued
    logic             op2_valid_reg;
    pix_op_t          op2_op_reg;
    logic [AW-1:0]    op2_addr_reg, op2_addr_next;

    // stage 3: read data back, modify and write
    logic             op3_valid_reg;
    pix_op_t          op3_op_reg;
    logic [AW-1:0]    op3_addr_reg;
    logic             fwd_hit_reg, fwd_hit_next;
    logic [23:0]      fwd_data_reg;

    // result
    logic             out_valid_reg, out_valid_next;
    pix_t             out_data_reg, out_data_next;

    logic [DIM_W-1:0] in_x, in_y;
    logic             in_inside;
    logic [DIM_W:0]   x_sum, y_sum, x_end_c, y_end_c;
    logic             rect_any;
    logic [LW-1:0]    clr_n;
    logic             read_busy;
    logic             accept;
    logic [DIM_W-1:0] row;
    logic [LW-1:0]    prod;
    logic [LW:0]      lin;
    logic [23:0]      ram_rdata, old_px, wr_px;
    logic             wr_en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= sat_dim(DIM_W'(512), MAX_WIDTH);
            fh_reg <= sat_dim(DIM_W'(512), MAX_HEIGHT);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FRAME_WIDTH: begin
                    fw_reg <= sat_dim(cfg_data, MAX_WIDTH);
                end
                CFG_FRAME_HEIGHT: begin
                    fh_reg <= sat_dim(cfg_data, MAX_HEIGHT);
                end
                default: begin
                end
            endcase
        end
    end

    // command decode and clipping
    assign in_x      = {1'b0, s_data.x_pos};
    assign in_y      = {1'b0, s_data.y_pos};
    assign in_inside = (in_x < fw_reg) && (in_y < fh_reg);
    assign x_sum     = {1'b0, in_x} + {1'b0, s_data.rect_width};
    assign y_sum     = {1'b0, in_y} + {1'b0, s_data.rect_height};
    assign x_end_c   = (x_sum < {1'b0, fw_reg}) ? x_sum : {1'b0, fw_reg};
    assign y_end_c   = (y_sum < {1'b0, fh_reg}) ? y_sum : {1'b0, fh_reg};
    assign rect_any  = ({1'b0, in_x} < x_end_c) && ({1'b0, in_y} < y_end_c);
    assign clr_n     = LW'(fw_reg) * LW'(fh_reg);

    assign read_busy = out_valid_reg || (op1_valid_reg && op1_op_reg.rd)
                    || (op2_valid_reg && op2_op_reg.rd) || (op3_valid_reg && op3_op_reg.rd);
    assign s_ready   = (state_reg == GEN_IDLE) && !((s_data.kind == KIND_READ) && read_busy);
    assign accept    = s_valid && s_ready;

    always_comb begin
        state_next      = state_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        x_start_next    = x_start_reg;
        x_end_next      = x_end_reg;
        y_end_next      = y_end_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_last_next   = clr_last_reg;
        color_next      = color_reg;
        alpha_next      = alpha_reg;
        blend_next      = blend_reg;
        op1_valid_next  = 1'b0;
        op1_op_next     = op1_op_reg;
        op1_direct_next = op1_direct_reg;
        op1_x_next      = op1_x_reg;
        op1_y_next      = op1_y_reg;
        op1_lin_next    = op1_lin_reg;
        case (state_reg)
            GEN_IDLE: begin
                if (accept) begin
                    case (s_data.kind)
                        KIND_CLEAR: begin
                            state_next    = GEN_CLEAR;
                            clr_cnt_next  = '0;
                            clr_last_next = clr_n - LW'(1);
                            color_next    = {s_data.red, s_data.green, s_data.blue};
                        end
                        KIND_SOLID_PIXEL, KIND_BLEND_PIXEL, KIND_READ: begin
                            op1_valid_next  = in_inside || (s_data.kind == KIND_READ);
                            op1_direct_next = 1'b0;
                            op1_x_next      = in_x;
                            op1_y_next      = in_y;
                            op1_op_next.rd    = (s_data.kind == KIND_READ);
                            op1_op_next.blend = (s_data.kind == KIND_BLEND_PIXEL);
                            op1_op_next.zero  = !in_inside;
                            op1_op_next.color = {s_data.red, s_data.green, s_data.blue};
                            op1_op_next.alpha = s_data.alpha;
                        end
                        KIND_SOLID_RECT, KIND_BLEND_RECT: begin
                            if (rect_any) begin
                                state_next   = GEN_RECT;
                                cur_x_next   = in_x;
                                cur_y_next   = in_y;
                                x_start_next = in_x;
                                x_end_next   = x_end_c;
                                y_end_next   = y_end_c;
                                color_next   = {s_data.red, s_data.green, s_data.blue};
                                alpha_next   = s_data.alpha;
                                blend_next   = (s_data.kind == KIND_BLEND_RECT);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            GEN_RECT: begin
                op1_valid_next    = 1'b1;
                op1_direct_next   = 1'b0;
                op1_x_next        = cur_x_reg;
                op1_y_next        = cur_y_reg;
                op1_op_next.rd    = 1'b0;
                op1_op_next.blend = blend_reg;
                op1_op_next.zero  = 1'b0;
                op1_op_next.color = color_reg;
                op1_op_next.alpha = alpha_reg;
                if (({1'b0, cur_x_reg} + (DIM_W+1)'(1)) == x_end_reg) begin
                    cur_x_next = x_start_reg;
                    if (({1'b0, cur_y_reg} + (DIM_W+1)'(1)) == y_end_reg) begin
                        state_next = GEN_IDLE;
                    end else begin
                        cur_y_next = cur_y_reg + DIM_W'(1);
                    end
                end else begin
                    cur_x_next = cur_x_reg + DIM_W'(1);
                end
            end
            GEN_CLEAR: begin
                op1_valid_next    = 1'b1;
                op1_direct_next   = 1'b1;
                op1_lin_next      = clr_cnt_reg;
                op1_op_next.rd    = 1'b0;
                op1_op_next.blend = 1'b0;
                op1_op_next.zero  = 1'b0;
                op1_op_next.color = color_reg;
                op1_op_next.alpha = alpha_reg;
                if (clr_cnt_reg == clr_last_reg) begin
                    state_next = GEN_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + LW'(1);
                end
            end
            default: begin
                state_next = GEN_IDLE;
            end
        endcase
    end

    // bottom-up row order
    assign row  = fh_reg - DIM_W'(1) - op1_y_reg;
    assign prod = LW'(row) * LW'(fw_reg);
    assign lin  = {1'b0, prod} + (LW+1)'(op1_x_reg);
    assign op2_addr_next = op1_direct_reg ? AW'(op1_lin_reg) : AW'(lin);

    ffbe_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (op3_addr_reg),
        .wr_data (wr_px),
        .rd_en   (op2_valid_reg),
        .rd_addr (op2_addr_reg),
        .rd_data (ram_rdata)
    );

    // read-modify-write with one-deep forwarding of the previous write
    assign old_px = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign wr_en  = op3_valid_reg && !op3_op_reg.rd;
    assign wr_px  = op3_op_reg.blend
        ? {mix(op3_op_reg.alpha, op3_op_reg.color[23:16], old_px[23:16]),
           mix(op3_op_reg.alpha, op3_op_reg.color[15:8],  old_px[15:8]),
           mix(op3_op_reg.alpha, op3_op_reg.color[7:0],   old_px[7:0])}
        : op3_op_reg.color;
    assign fwd_hit_next = wr_en && op2_valid_reg && (op2_addr_reg == op3_addr_reg);

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (op3_valid_reg && op3_op_reg.rd) begin
            out_valid_next = 1'b1;
            out_data_next  = op3_op_reg.zero ? '0 : pix_t'(old_px);
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= GEN_IDLE;
            op1_valid_reg <= 1'b0;
            op2_valid_reg <= 1'b0;
            op3_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            op1_valid_reg <= op1_valid_next;
            op2_valid_reg <= op1_valid_reg;
            op3_valid_reg <= op2_valid_reg;
            fwd_hit_reg   <= fwd_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_x_reg      <= cur_x_next;
        cur_y_reg      <= cur_y_next;
        x_start_reg    <= x_start_next;
        x_end_reg      <= x_end_next;
        y_end_reg      <= y_end_next;
        clr_cnt_reg    <= clr_cnt_next;
        clr_last_reg   <= clr_last_next;
        color_reg      <= color_next;
        alpha_reg      <= alpha_next;
        blend_reg      <= blend_next;
        op1_op_reg     <= op1_op_next;
        op1_direct_reg <= op1_direct_next;
        op1_x_reg      <= op1_x_next;
        op1_y_reg      <= op1_y_next;
        op1_lin_reg    <= op1_lin_next;
        op2_op_reg     <= op1_op_reg;
        op2_addr_reg   <= op2_addr_next;
        op3_op_reg     <= op2_op_reg;
        op3_addr_reg   <= op2_addr_reg;
        fwd_data_reg   <= wr_px;
        out_data_reg   <= out_data_next;
    end

    // at most one read in flight or waiting, so a result is never overwritten
    a_one_read: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({out_valid_reg, op1_valid_reg && op1_op_reg.rd,
                    op2_valid_reg && op2_op_reg.rd, op3_valid_reg && op3_op_reg.rd}) <= 1)
        else $error("more than one read transaction in flight");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != GEN_IDLE) |-> !s_ready)
        else $error("command accepted while generator busy");

    a_rect_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == GEN_RECT) |-> (({1'b0, cur_x_reg} < x_end_reg)
            && ({1'b0, cur_y_reg} < y_end_reg) && (x_end_reg <= {1'b0, fw_reg})
            && (y_end_reg <= {1'b0, fh_reg})))
        else $error("rectangle cursor outside clipped frame");

    a_clear_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == GEN_CLEAR) |-> (clr_cnt_reg <= clr_last_reg))
        else $error("clear sweep past end of frame");

    a_fwd_source: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_hit_reg |-> op3_valid_reg && $past(wr_en))
        else $error("forwarded data without a preceding write");

endmodule
`default_nettype wire
